/* rtl/icsc_pkg.sv */
`default_nettype none

package icsc_pkg;

  // Result status codes, in falling priority after ok.
  typedef enum logic [2:0] {
    StatusOk          = 3'd0,
    StatusSyntax      = 3'd1,
    StatusOctetCount  = 3'd2,
    StatusOctetRange  = 3'd3,
    StatusPrefixRange = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [31:0] net_mask;
    logic [31:0] network_addr;
    logic [31:0] broadcast_addr;
    logic [31:0] first_host;
    logic [31:0] last_host;
    logic [31:0] host_count;
    logic [4:0]  class_code;
    logic        network_valid;
    logic        broadcast_valid;
  } out_t;

  // One parsed text, handed from the scanner to the subnet unit.
  typedef struct packed {
    status_e     status;
    logic [31:0] addr;
    logic [5:0]  prefix;
  } rec_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam int unsigned RuleCount = 16;
  localparam int unsigned RuleIdxW  = $clog2(RuleCount);

  // Only the this-network rule is skipped for a zero prefix.
  localparam int unsigned RuleThisNet = 2;

  localparam logic [4:0] ClassPublicA = 5'd16;
  localparam logic [4:0] ClassPublicB = 5'd17;
  localparam logic [4:0] ClassPublicC = 5'd18;

  localparam logic [7:0] PublicAMax = 8'd127;
  localparam logic [7:0] PublicBMax = 8'd191;

  localparam logic [31:0] RuleAddr [RuleCount] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h6440_0000,
    32'h7F00_0000, 32'hA9FE_0000, 32'hC000_0000, 32'hC000_0200,
    32'hC612_0000, 32'hC633_6400, 32'hCB00_7100, 32'h0A00_0000,
    32'hAC10_0000, 32'hC0A8_0000, 32'hE000_0000, 32'hF000_0000
  };

  localparam logic [31:0] RuleMask [RuleCount] = '{
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF00_0000, 32'hFFC0_0000,
    32'hFF00_0000, 32'hFFFF_0000, 32'hFFFF_FF00, 32'hFFFF_FF00,
    32'hFFFE_0000, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFF00_0000,
    32'hFFF0_0000, 32'hFFFF_0000, 32'hF000_0000, 32'hF000_0000
  };

endpackage

`default_nettype wire

/* rtl/icsc_scan.sv */
`default_nettype none

// Character scanner: checks the syntax of A.B.C.D/P and accumulates the fields.
module icsc_scan (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire icsc_pkg::in_t   in_data_i,
  output logic                 rec_push_o,
  output icsc_pkg::rec_t       rec_o
);

  localparam logic [2:0] StStart = 3'd0;
  localparam logic [2:0] StOct   = 3'd1;
  localparam logic [2:0] StDot   = 3'd2;
  localparam logic [2:0] StSlash = 3'd3;
  localparam logic [2:0] StMsk   = 3'd4;

  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChSlash  = 8'h2F;

  localparam logic [8:0] OctetSat  = 9'd256;
  localparam logic [8:0] OctetMax  = 9'd255;
  localparam logic [5:0] PrefixSat = 6'd33;
  localparam logic [5:0] PrefixMax = 6'd32;
  localparam logic [2:0] SeenMax   = 3'd7;
  localparam logic [2:0] SeenAddr  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [2:0]  seen_q, seen_d;
  logic [8:0]  digit_q, digit_d;
  logic [31:0] addr_q, addr_d;
  logic [5:0]  prefix_q, prefix_d;
  logic        syn_bad_q, syn_bad_d;
  logic        oct_bad_q, oct_bad_d;

  logic        is_digit, is_dot, is_slash;
  logic [3:0]  dval;
  logic [11:0] oct_acc;
  logic [8:0]  pfx_acc;
  logic        close_oct;
  icsc_pkg::status_e status;

  assign is_digit = (in_data_i.char_code >= ChDigit0) && (in_data_i.char_code <= ChDigit9);
  assign is_dot   = (in_data_i.char_code == ChDot);
  assign is_slash = (in_data_i.char_code == ChSlash);
  assign dval     = is_digit ? in_data_i.char_code[3:0] : 4'd0;
  assign oct_acc  = {3'd0, digit_q} * 12'd10 + {8'd0, dval};
  assign pfx_acc  = (state_q == StSlash) ? {5'd0, dval}
                                         : {3'd0, prefix_q} * 9'd10 + {5'd0, dval};

  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    digit_d   = digit_q;
    addr_d    = addr_q;
    prefix_d  = prefix_q;
    syn_bad_d = syn_bad_q;
    oct_bad_d = oct_bad_q;
    close_oct = 1'b0;
    if (!syn_bad_q) begin
      unique case (state_q)
        StStart, StDot: begin
          if (is_digit) begin
            digit_d = {5'd0, dval};
            state_d = StOct;
          end else begin
            syn_bad_d = 1'b1;
          end
        end
        StOct: begin
          if (is_digit) begin
            digit_d = (oct_acc > {3'd0, OctetSat}) ? OctetSat : oct_acc[8:0];
          end else if (is_dot) begin
            close_oct = 1'b1;
            state_d   = StDot;
          end else if (is_slash) begin
            close_oct = 1'b1;
            state_d   = StSlash;
          end else begin
            syn_bad_d = 1'b1;
          end
        end
        StSlash, StMsk: begin
          if (is_digit) begin
            prefix_d = (pfx_acc > {3'd0, PrefixSat}) ? PrefixSat : pfx_acc[5:0];
            state_d  = StMsk;
          end else begin
            syn_bad_d = 1'b1;
          end
        end
        default: syn_bad_d = 1'b1;
      endcase
    end
    if (close_oct) begin
      if (seen_q < SeenAddr) begin
        if (digit_q > OctetMax) begin
          oct_bad_d = 1'b1;
        end
        addr_d = {addr_q[23:0], digit_q[7:0]};
      end
      if (seen_q < SeenMax) begin
        seen_d = seen_q + 3'd1;
      end
      digit_d = 9'd0;
    end
  end

  always_comb begin
    if (syn_bad_d || (state_d != StMsk)) begin
      status = icsc_pkg::StatusSyntax;
    end else if (seen_d != SeenAddr) begin
      status = icsc_pkg::StatusOctetCount;
    end else if (oct_bad_d) begin
      status = icsc_pkg::StatusOctetRange;
    end else if (prefix_d > PrefixMax) begin
      status = icsc_pkg::StatusPrefixRange;
    end else begin
      status = icsc_pkg::StatusOk;
    end
  end

  assign rec_push_o    = accept_i && in_data_i.last_char;
  assign rec_o.status  = status;
  assign rec_o.addr    = addr_d;
  assign rec_o.prefix  = prefix_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StStart;
      seen_q    <= 3'd0;
      digit_q   <= 9'd0;
      addr_q    <= 32'd0;
      prefix_q  <= 6'd0;
      syn_bad_q <= 1'b0;
      oct_bad_q <= 1'b0;
    end else if (accept_i) begin
      if (in_data_i.last_char) begin
        // The flagged character closes the text; start over for the next one.
        state_q   <= StStart;
        seen_q    <= 3'd0;
        digit_q   <= 9'd0;
        addr_q    <= 32'd0;
        prefix_q  <= 6'd0;
        syn_bad_q <= 1'b0;
        oct_bad_q <= 1'b0;
      end else begin
        state_q   <= state_d;
        seen_q    <= seen_d;
        digit_q   <= digit_d;
        addr_q    <= addr_d;
        prefix_q  <= prefix_d;
        syn_bad_q <= syn_bad_d;
        oct_bad_q <= oct_bad_d;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/icsc_fifo.sv */
`default_nettype none

// Small queue of parsed texts between the scanner and the subnet unit.
module icsc_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire icsc_pkg::rec_t wr_data_i,
  output logic                full_o,
  input  wire logic           rd_en_i,
  output logic                valid_o,
  output icsc_pkg::rec_t      rd_data_o
);

  localparam int unsigned CntW = $clog2(icsc_pkg::QueueDepth + 1);

  icsc_pkg::rec_t                  mem_q [icsc_pkg::QueueDepth];
  logic [icsc_pkg::QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]                 count_q;
  logic                            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(icsc_pkg::QueueDepth));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == icsc_pkg::QueuePtrW'(icsc_pkg::QueueDepth - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == icsc_pkg::QueuePtrW'(icsc_pkg::QueueDepth - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(icsc_pkg::QueueDepth))
    else $error("queue count beyond its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

/* rtl/icsc_calc.sv */
`default_nettype none

// Subnet unit: two stages, mask and rule match first, then hosts and output.
module icsc_calc (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           rec_valid_i,
  input  wire icsc_pkg::rec_t rec_i,
  output logic                rec_pop_o,
  output logic                empty,
  input  wire logic           pop,
  output icsc_pkg::out_t      out_data_o
);

  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] ClearLsb = 32'hFFFF_FFFE;
  localparam logic [5:0]  Prefix31 = 6'd31;
  localparam logic [5:0]  Prefix32 = 6'd32;

  typedef struct packed {
    icsc_pkg::status_e status;
    logic [31:0]       addr;
    logic [5:0]        prefix;
    logic [31:0]       mask;
    logic [31:0]       net;
    logic [31:0]       bcast;
    logic [4:0]        cls;
    logic              net_ok;
    logic              bc_ok;
  } stage_t;

  stage_t              a_q, a_d;
  logic                a_valid_q, b_valid_q;
  icsc_pkg::out_t      b_q, b_d;
  logic                a_ready, b_ready;
  logic [31:0]         mask;
  logic                hit;
  logic [4:0]          cls;
  logic                p31, p32;

  assign b_ready   = !b_valid_q || pop;
  assign a_ready   = !a_valid_q || b_ready;
  assign rec_pop_o = rec_valid_i && a_ready;
  assign empty     = !b_valid_q;
  assign out_data_o = b_q;

  // Stage A: mask, network, broadcast and class.
  assign mask = ~(AllOnes >> rec_i.prefix);

  always_comb begin
    hit = 1'b0;
    cls = '0;
    for (int i = icsc_pkg::RuleCount - 1; i >= 0; i--) begin
      if (((rec_i.addr & icsc_pkg::RuleMask[i]) == icsc_pkg::RuleAddr[i]) &&
          !((i == icsc_pkg::RuleThisNet) && (rec_i.prefix == 6'd0))) begin
        hit = 1'b1;
        cls = 5'(i);
      end
    end
    if (!hit) begin
      if (rec_i.addr[31:24] <= icsc_pkg::PublicAMax) begin
        cls = icsc_pkg::ClassPublicA;
      end else if (rec_i.addr[31:24] <= icsc_pkg::PublicBMax) begin
        cls = icsc_pkg::ClassPublicB;
      end else begin
        cls = icsc_pkg::ClassPublicC;
      end
    end
  end

  always_comb begin
    a_d.status = rec_i.status;
    a_d.addr   = rec_i.addr;
    a_d.prefix = rec_i.prefix;
    a_d.mask   = mask;
    a_d.net_ok = (rec_i.prefix != Prefix31);
    a_d.bc_ok  = (rec_i.prefix < Prefix31);
    a_d.net    = a_d.net_ok ? (rec_i.addr & mask) : 32'd0;
    a_d.bcast  = a_d.bc_ok ? (a_d.net | ~mask) : 32'd0;
    a_d.cls    = cls;
  end

  // Stage B: host range and count. Below /31 the host part of the network is
  // all zeros and of the broadcast all ones, so +1 and -1 only touch bit 0.
  assign p31 = (a_q.prefix == Prefix31);
  assign p32 = (a_q.prefix == Prefix32);

  always_comb begin
    b_d = '0;
    b_d.status = a_q.status;
    if (a_q.status == icsc_pkg::StatusOk) begin
      b_d.address         = a_q.addr;
      b_d.prefix_len      = a_q.prefix;
      b_d.net_mask        = a_q.mask;
      b_d.network_addr    = a_q.net;
      b_d.broadcast_addr  = a_q.bcast;
      b_d.class_code      = a_q.cls;
      b_d.network_valid   = a_q.net_ok;
      b_d.broadcast_valid = a_q.bc_ok;
      b_d.first_host      = (p31 || p32) ? a_q.addr : (a_q.net | 32'd1);
      if (p32) begin
        b_d.last_host  = a_q.addr;
        b_d.host_count = 32'd1;
      end else if (p31) begin
        b_d.last_host  = a_q.addr + 32'd1;
        b_d.host_count = 32'd2;
      end else begin
        b_d.last_host  = a_q.bcast & ClearLsb;
        b_d.host_count = ~a_q.mask & ClearLsb;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= rec_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      a_q <= a_d;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (b_q.status != icsc_pkg::StatusOk)) |->
      ((b_q.address == 32'd0) && (b_q.host_count == 32'd0)))
    else $error("error result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (b_q.status == icsc_pkg::StatusOk)) |->
      ((b_q.network_valid == (b_q.prefix_len != Prefix31)) &&
       (b_q.broadcast_valid == (b_q.prefix_len < Prefix31))))
    else $error("validity flags disagree with prefix");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (b_q.status == icsc_pkg::StatusOk)) |-> (b_q.host_count != 32'd0))
    else $error("good result with no hosts");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_ready) |=> a_valid_q)
    else $error("stage A dropped a request under stall");

endmodule

`default_nettype wire

/* rtl/ipv4_cidr_text_subnet_calc_core.sv */
// IPv4 CIDR subnet calculator.
// The input side is a queue: drive one ASCII character of "A.B.C.D/P" on
// in_data_i with push; a request is taken at a rising edge with push high and
// full low. Set last_char on the final character of each text.
// The result side is a queue too: while empty is low, out_data_o holds the
// oldest result, and it is taken at a rising edge with pop high.
// Exactly one result comes out per text, on its flagged character; other
// characters only advance the scanner. A result carries a status code and,
// when the status is ok, the address, prefix, mask, network, broadcast, host
// range, host count and class code; on any error all other fields are zero.
// A flagged character's record is written to the queue, then registered in
// the match stage and then the output stage. Throughput is one character per
// cycle while full is low; results leave at one per cycle while pop is high.
// When the result side stalls, the output register, the match stage and the
// two-entry queue fill in turn; full then rises and holds off new characters
// until pop frees a slot. Until the queue is full every character is taken;
// while full is high none is, even one that would produce no result.
// Reset clears the scanner to its start state and empties both queues.
`default_nettype none

module ipv4_cidr_text_subnet_calc_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire icsc_pkg::in_t   in_data_i,
  output logic                 empty,
  input  wire logic            pop,
  output icsc_pkg::out_t       out_data_o
);

  logic           accept;
  logic           rec_push;
  icsc_pkg::rec_t rec_wr;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  icsc_pkg::rec_t q_rd;

  // Only a flagged character needs a queue slot, but full is kept simple and
  // conservative so that the input never depends on the character itself.
  assign full   = q_full;
  assign accept = push && !full;

  icsc_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_wr)
  );

  icsc_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rec_push),
    .wr_data_i (rec_wr),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (q_rd)
  );

  icsc_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_valid),
    .rec_i       (q_rd),
    .rec_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* sim/ipv4_cidr_text_subnet_calc_core_test.sv */
`timescale 1ns / 1ps

module ipv4_cidr_text_subnet_calc_core_test;

  // Scanner states of the text parser, as the predictor tracks them.
  typedef enum logic [2:0] {
    ScanStart  = 3'd0,
    ScanOctet  = 3'd1,
    ScanDot    = 3'd2,
    ScanSlash  = 3'd3,
    ScanPrefix = 3'd4
  } scan_e;

  // Special-use address blocks, checked in this order; the first hit wins.
  localparam int SpecialCount = 16;
  localparam int ThisNetRule  = 2;
  localparam logic [31:0] SpecialBase [SpecialCount] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h6440_0000,
    32'h7F00_0000, 32'hA9FE_0000, 32'hC000_0000, 32'hC000_0200,
    32'hC612_0000, 32'hC633_6400, 32'hCB00_7100, 32'h0A00_0000,
    32'hAC10_0000, 32'hC0A8_0000, 32'hE000_0000, 32'hF000_0000
  };
  localparam logic [31:0] SpecialMask [SpecialCount] = '{
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF00_0000, 32'hFFC0_0000,
    32'hFF00_0000, 32'hFFFF_0000, 32'hFFFF_FF00, 32'hFFFF_FF00,
    32'hFFFE_0000, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFF00_0000,
    32'hFFF0_0000, 32'hFFFF_0000, 32'hF000_0000, 32'hF000_0000
  };
  localparam logic [7:0] ClassALimit = 8'd127;
  localparam logic [7:0] ClassBLimit = 8'd191;

  localparam int CharTarget   = 1900;
  localparam int PrintLimit   = 50;
  localparam int DrainCycles  = 10;

  // The scoreboard mirrors the parser state and keeps the subnet results
  // that accepted requests are expected to produce, oldest first.
  class subnet_scoreboard;
    scan_e          scan;
    bit [2:0]       octets;
    bit [8:0]       digit;
    bit [31:0]      addr_acc;
    bit [5:0]       prefix;
    bit             syntax_err;
    bit             octet_err;
    icsc_pkg::out_t pending_q[$];
    int unsigned    mismatches;

    function new();
      mismatches = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      scan       = ScanStart;
      octets     = 3'd0;
      digit      = 9'd0;
      addr_acc   = 32'd0;
      prefix     = 6'd0;
      syntax_err = 1'b0;
      octet_err  = 1'b0;
    endfunction

    // Only the first four octets land in the address; the count saturates.
    function void close_octet();
      if (octets < 3'd4) begin
        if (digit > 9'd255) octet_err = 1'b1;
        addr_acc = {addr_acc[23:0], digit[7:0]};
      end
      if (octets < 3'd7) octets = octets + 3'd1;
      digit = 9'd0;
    endfunction

    function void scan_char(bit [7:0] c);
      bit is_digit;
      int d;
      int v;
      is_digit = (c >= "0") && (c <= "9");
      d = is_digit ? int'(c) - int'("0") : 0;
      if (syntax_err) return;
      case (scan)
        ScanStart, ScanDot: begin
          if (is_digit) begin
            digit = 9'(d);
            scan = ScanOctet;
          end else begin
            syntax_err = 1'b1;
          end
        end
        ScanOctet: begin
          if (is_digit) begin
            v = int'(digit) * 10 + d;
            digit = (v > 256) ? 9'd256 : 9'(v);
          end else if (c == ".") begin
            close_octet();
            scan = ScanDot;
          end else if (c == "/") begin
            close_octet();
            scan = ScanSlash;
          end else begin
            syntax_err = 1'b1;
          end
        end
        ScanSlash, ScanPrefix: begin
          if (is_digit) begin
            v = (scan == ScanSlash) ? d : int'(prefix) * 10 + d;
            prefix = (v > 33) ? 6'd33 : 6'(v);
            scan = ScanPrefix;
          end else begin
            syntax_err = 1'b1;
          end
        end
        default: syntax_err = 1'b1;
      endcase
    endfunction

    function icsc_pkg::out_t subnet_result();
      icsc_pkg::out_t r;
      bit [31:0] a;
      bit [31:0] m;
      bit [31:0] net;
      bit [31:0] bc;
      bit [63:0] span;
      bit        found;
      int        p;
      int        i;
      r = '0;
      if (syntax_err || scan != ScanPrefix) r.status = icsc_pkg::StatusSyntax;
      else if (octets != 3'd4)              r.status = icsc_pkg::StatusOctetCount;
      else if (octet_err)                   r.status = icsc_pkg::StatusOctetRange;
      else if (prefix > 6'd32)              r.status = icsc_pkg::StatusPrefixRange;
      else                                  r.status = icsc_pkg::StatusOk;
      if (r.status != icsc_pkg::StatusOk) return r;

      a = addr_acc;
      p = int'(prefix);
      m = (p == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - p));
      net = (p != 31) ? (a & m) : 32'd0;
      bc = (p < 31) ? (net | ~m) : 32'd0;
      r.address         = a;
      r.prefix_len      = prefix;
      r.net_mask        = m;
      r.network_addr    = net;
      r.broadcast_addr  = bc;
      r.network_valid   = (p != 31);
      r.broadcast_valid = (p < 31);
      if (p == 32) begin
        r.first_host = a;
        r.last_host  = a;
        r.host_count = 32'd1;
      end else if (p == 31) begin
        r.first_host = a;
        r.last_host  = a + 32'd1;
        r.host_count = 32'd2;
      end else begin
        span = (64'd1 << (32 - p)) - 64'd2;
        r.first_host = net + 32'd1;
        r.last_host  = bc - 32'd1;
        r.host_count = span[31:0];
      end

      // The this-network block does not apply to a zero prefix.
      found = 1'b0;
      for (i = 0; i < SpecialCount; i++) begin
        if (!found && (a & SpecialMask[i]) == SpecialBase[i] &&
            !(i == ThisNetRule && p == 0)) begin
          r.class_code = 5'(i);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (a[31:24] <= ClassALimit)      r.class_code = icsc_pkg::ClassPublicA;
        else if (a[31:24] <= ClassBLimit) r.class_code = icsc_pkg::ClassPublicB;
        else                              r.class_code = icsc_pkg::ClassPublicC;
      end
      return r;
    endfunction

    function void note_request(icsc_pkg::in_t req);
      scan_char(req.char_code);
      if (req.last_char) begin
        pending_q.push_back(subnet_result());
        clear_parser();
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < PrintLimit)
        $display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(icsc_pkg::out_t got);
      icsc_pkg::out_t want;
      if (pending_q.size() == 0) begin
        report("result with nothing pending", 32'(got.status), 32'd0);
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.address !== want.address)
        report("address", got.address, want.address);
      if (got.prefix_len !== want.prefix_len)
        report("prefix_len", 32'(got.prefix_len), 32'(want.prefix_len));
      if (got.net_mask !== want.net_mask)
        report("net_mask", got.net_mask, want.net_mask);
      if (got.network_addr !== want.network_addr)
        report("network_addr", got.network_addr, want.network_addr);
      if (got.broadcast_addr !== want.broadcast_addr)
        report("broadcast_addr", got.broadcast_addr, want.broadcast_addr);
      if (got.first_host !== want.first_host)
        report("first_host", got.first_host, want.first_host);
      if (got.last_host !== want.last_host)
        report("last_host", got.last_host, want.last_host);
      if (got.host_count !== want.host_count)
        report("host_count", got.host_count, want.host_count);
      if (got.class_code !== want.class_code)
        report("class_code", 32'(got.class_code), 32'(want.class_code));
      if (got.network_valid !== want.network_valid)
        report("network_valid", 32'(got.network_valid), 32'(want.network_valid));
      if (got.broadcast_valid !== want.broadcast_valid)
        report("broadcast_valid", 32'(got.broadcast_valid), 32'(want.broadcast_valid));
    endtask
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           push;
  logic           full;
  icsc_pkg::in_t  in_data;
  logic           empty;
  logic           pop;
  icsc_pkg::out_t out_data;

  subnet_scoreboard sb;
  bit [7:0]         text_q[$];
  int               sent_chars;
  bit               idle_in;
  bit               idle_out;
  int               stall_left;

  ipv4_cidr_text_subnet_calc_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The result side pops at the falling edge. Besides the scattered idle
  // cycles there are occasional longer stalls, so that the output stages and
  // the internal queue fill up and full gets asserted.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (idle_out && $urandom_range(99) < 35) begin
      if ($urandom_range(9) == 0) stall_left <= $urandom_range(20, 3);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Results are sampled at the rising edge, where pop and empty are stable.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_data);
  end

  // One request: optional idle cycles first, then push until the block takes
  // it. The task returns at a falling edge, ready for the next request, so
  // push stays high across back-to-back requests.
  task automatic send_char(icsc_pkg::in_t req);
    while (idle_in && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    in_data <= req;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_request(req);
    sent_chars++;
    @(negedge clk_i);
  endtask

  // Sends the text in text_q, with last_char set on its final character.
  task automatic send_text();
    icsc_pkg::in_t req;
    int i;
    for (i = 0; i < text_q.size(); i++) begin
      req.char_code = text_q[i];
      req.last_char = (i == text_q.size() - 1);
      send_char(req);
    end
  endtask

  function automatic void load_string(string s);
    int i;
    text_q.delete();
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Mostly characters the scanner cares about, otherwise any byte at all.
  function automatic bit [7:0] random_char();
    string alphabet;
    alphabet = "0123456789./";
    if ($urandom_range(1) == 0) return alphabet[$urandom_range(11)];
    return 8'($urandom_range(255));
  endfunction

  // Builds a CIDR text. The fault argument picks one deliberate error:
  // 0 none, 1 wrong octet count, 2 octet out of range, 3 prefix out of range.
  function automatic string make_cidr(int fault);
    string     s;
    bit [31:0] a;
    int        n_oct;
    int        bad_idx;
    int        idx;
    int        v;
    int        i;
    int        counts [6];
    counts = '{1, 2, 3, 5, 6, 8};
    n_oct = (fault == 1) ? counts[$urandom_range(5)] : 4;
    if ($urandom_range(1) == 0) begin
      idx = $urandom_range(SpecialCount - 1);
      a = SpecialBase[idx] | ($urandom & ~SpecialMask[idx]);
    end else begin
      a = $urandom;
    end
    bad_idx = $urandom_range(n_oct - 1);
    s = "";
    for (i = 0; i < n_oct; i++) begin
      if (i < 4) v = int'(a[31 - 8 * i -: 8]);
      else       v = $urandom_range(255);
      if ($urandom_range(7) == 0) v = ($urandom_range(1) == 0) ? 0 : 255;
      if (fault == 2 && i == bad_idx)
        v = ($urandom_range(2) == 0) ? $urandom_range(99999, 1000) : $urandom_range(999, 256);
      if ($urandom_range(9) == 0) s = {s, "0"};
      s = {s, $sformatf("%0d", v), (i == n_oct - 1) ? "/" : "."};
    end
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = 31;
      2:       v = 32;
      3:       v = 1;
      4:       v = 30;
      default: v = $urandom_range(32);
    endcase
    if (fault == 3) v = $urandom_range(999, 33);
    if ($urandom_range(9) == 0) s = {s, "0"};
    return {s, $sformatf("%0d", v)};
  endfunction

  // Random text: mostly well formed, some with a single semantic fault, some
  // with a damaged character sequence, and a few that are pure noise.
  function automatic void make_random_text();
    int kind;
    int pos;
    int len;
    int i;
    kind = $urandom_range(99);
    if (kind < 70) begin
      load_string(make_cidr(0));
    end else if (kind < 80) begin
      load_string(make_cidr($urandom_range(3, 1)));
    end else if (kind < 92) begin
      load_string(make_cidr(0));
      pos = $urandom_range(text_q.size() - 1);
      case ($urandom_range(3))
        0: text_q[pos] = random_char();
        1: text_q.insert(pos, random_char());
        2: if (text_q.size() > 1) text_q.delete(pos);
        default: begin
          len = $urandom_range(text_q.size() - 1, 1);
          while (text_q.size() > len) void'(text_q.pop_back());
        end
      endcase
    end else begin
      text_q.delete();
      len = $urandom_range(8, 1);
      for (i = 0; i < len; i++) text_q.push_back(random_char());
    end
  endfunction

  initial begin
    sb         = new();
    rst_ni     = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    in_data    = '0;
    sent_chars = 0;
    stall_left = 0;
    idle_in    = 1'b1;
    idle_out   = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed texts: a lone flagged character, a zero prefix on a 0/8
    // address (the this-network block must be skipped), a point-to-point
    // /31, and a lone flagged non-ASCII byte.
    load_string("A");
    send_text();
    load_string("0.1.2.3/0");
    send_text();
    load_string("9.9.9.9/31");
    send_text();
    text_q.delete();
    text_q.push_back(8'hFF);
    send_text();

    // Random texts. A stretch in the middle runs with both sides at full
    // rate, the rest with random idle cycles on both sides.
    while (sent_chars < CharTarget) begin
      idle_in  = !(sent_chars >= 700 && sent_chars < 1000);
      idle_out = idle_in;
      make_random_text();
      send_text();
    end
    push <= 1'b0;
    idle_out = 1'b1;

    // Let every pending result drain, then keep watching the output
    // so that any stray extra result would still be caught.
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* ipv4_cidr_text_subnet_calc_core.f */
rtl/icsc_pkg.sv
rtl/icsc_scan.sv
rtl/icsc_fifo.sv
rtl/icsc_calc.sv
rtl/ipv4_cidr_text_subnet_calc_core.sv
sim/ipv4_cidr_text_subnet_calc_core_test.sv
